// ===== sv/trimmed_mean_angle_speed_assert.svh =====
// Assertion macros shared by the block's checker.
// No dependencies; include by bare file name inside a module body.
`ifndef TRIMMED_MEAN_ANGLE_SPEED_ASSERT_SVH
`define TRIMMED_MEAN_ANGLE_SPEED_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TMAS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tmas assertion failed");

// Next-cycle implication, disabled during reset.
`define TMAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tmas assertion failed");

`endif

// ===== sv/tmas_pkg.sv =====
// Types and constants for the trimmed-mean angle speed block.
// No dependencies; used by the top level and its checker.
`default_nettype none

package tmas_pkg;

  localparam int NCH = 3;

  typedef logic signed [31:0] angle_t;
  typedef logic signed [35:0] sum_t;
  typedef logic signed [36:0] trim_t;
  typedef logic signed [31:0] mean_t;
  typedef logic signed [32:0] diff_t;
  typedef logic signed [43:0] prod_t;
  typedef logic signed [47:0] rate_t;
  typedef logic        [9:0]  gain_t;
  typedef logic        [3:0]  scnt_t;
  typedef logic        [1:0]  ccnt_t;

  localparam scnt_t WIN_FIRST = 4'd0;
  localparam scnt_t WIN_LAST  = 4'd9;
  localparam gain_t GAIN_RST  = 10'd10;
  localparam ccnt_t CHG_FULL  = 2'd3;

endpackage

`default_nettype wire

// ===== sv/trimmed_mean_angle_speed.sv =====
// After a window's tenth item is accepted, its result passes the trimmed mean, change/diff,
//   then gain multiply into the output register.
// Throughput: one item per cycle; results come at most once per ten items.
// The tenth item of a window waits only while the previous window's result is still
//   in flight or parked behind a full output register.
// Reset (rst_n low, synchronous): counters, valids and means cleared, gain back to 10.
`default_nettype none

module trimmed_mean_angle_speed (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input channel
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire tmas_pkg::angle_t in_pitch_angle,
  input  wire tmas_pkg::angle_t in_yaw_angle,
  input  wire tmas_pkg::angle_t in_feeder_angle,
  // result channel
  output logic                  out_valid,
  input  wire logic             out_ready,
  output tmas_pkg::rate_t       out_pitch_rate,
  output tmas_pkg::rate_t       out_yaw_rate,
  output tmas_pkg::rate_t       out_feeder_rate,
  // gain register write
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire tmas_pkg::gain_t  cfg_rate_gain
);

  import tmas_pkg::*;

  // channel order: pitch, yaw, feeder
  angle_t in_ang [NCH];
  assign in_ang[0] = in_pitch_angle;
  assign in_ang[1] = in_yaw_angle;
  assign in_ang[2] = in_feeder_angle;

  logic  in_acc;
  gain_t gain_r;

  // window accumulators
  scnt_t  scnt_r, scnt_nxt;
  sum_t   wsum_r [NCH];
  sum_t   wsum_nxt [NCH];
  angle_t wmax_r [NCH];
  angle_t wmax_nxt [NCH];
  angle_t wmin_r [NCH];
  angle_t wmin_nxt [NCH];
  logic   fin_vld_r;     // window regs hold a finished window this cycle

  // trimmed-mean stage
  mean_t  mean_now_r [NCH];
  mean_t  mean_last_r [NCH];
  mean_t  mean_nxt [NCH];
  trim_t  trim [NCH];
  logic   b_vld_r;

  // change count / difference stage
  ccnt_t  ccnt_r, ccnt_nxt;
  diff_t  diff_r [NCH];
  logic   c_pend_r, c_pend_nxt;
  logic   both_chg;

  // output register
  prod_t  prod [NCH];
  rate_t  rate_r [NCH];
  rate_t  rate_nxt [NCH];
  logic   out_valid_r, out_valid_nxt;
  logic   out_load;

  // Tenth item held back while a previous window result is still moving down.
  assign in_ready  = !((scnt_r == WIN_LAST) && (fin_vld_r || b_vld_r || c_pend_r));
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RST;
    end else if (cfg_valid) begin
      gain_r <= cfg_rate_gain;
    end
  end

  // ---- accumulate: first item of a window loads, later items add and compare
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      if (scnt_r == WIN_FIRST) begin
        wsum_nxt[c] = sum_t'(in_ang[c]);
        wmax_nxt[c] = in_ang[c];
        wmin_nxt[c] = in_ang[c];
      end else begin
        wsum_nxt[c] = wsum_r[c] + sum_t'(in_ang[c]);
        wmax_nxt[c] = (in_ang[c] > wmax_r[c]) ? in_ang[c] : wmax_r[c];
        wmin_nxt[c] = (in_ang[c] < wmin_r[c]) ? in_ang[c] : wmin_r[c];
      end
    end
    scnt_nxt = (scnt_r == WIN_LAST) ? WIN_FIRST : scnt_r + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scnt_r    <= WIN_FIRST;
      fin_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        scnt_r <= scnt_nxt;
      end
      fin_vld_r <= in_acc && (scnt_r == WIN_LAST);
    end
  end

  // Window regs hold the finished window in the cycle after the tenth item; the next item's
  // load at the same edge is safe since the mean stage samples the old value.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int c = 0; c < NCH; c++) begin
        wsum_r[c] <= wsum_nxt[c];
        wmax_r[c] <= wmax_nxt[c];
        wmin_r[c] <= wmin_nxt[c];
      end
    end
  end

  // ---- trimmed mean: (sum - max - min) >>> 3, floor toward minus infinity
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      trim[c]     = trim_t'(wsum_r[c]) - trim_t'(wmax_r[c]) - trim_t'(wmin_r[c]);
      mean_nxt[c] = mean_t'(trim[c] >>> 3);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
      for (int c = 0; c < NCH; c++) begin
        mean_now_r[c]  <= '0;
        mean_last_r[c] <= '0;
      end
    end else begin
      b_vld_r <= fin_vld_r;
      if (fin_vld_r) begin
        for (int c = 0; c < NCH; c++) begin
          mean_last_r[c] <= mean_now_r[c];
          mean_now_r[c]  <= mean_nxt[c];
        end
      end
    end
  end

  // ---- change count and mean difference
  assign both_chg = (mean_now_r[0] != mean_last_r[0]) && (mean_now_r[1] != mean_last_r[1]);

  always_comb begin
    ccnt_nxt = ccnt_r;
    if (b_vld_r && both_chg && (ccnt_r != CHG_FULL)) begin
      ccnt_nxt = ccnt_r + 2'd1;
    end
  end

  // output register takes the parked result when empty or being drained
  assign out_load = c_pend_r && (!out_valid_r || out_ready);

  always_comb begin
    c_pend_nxt = c_pend_r;
    if (b_vld_r) begin
      c_pend_nxt = (ccnt_nxt == CHG_FULL);
    end else if (out_load) begin
      c_pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccnt_r   <= '0;
      c_pend_r <= 1'b0;
    end else begin
      ccnt_r   <= ccnt_nxt;
      c_pend_r <= c_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_vld_r) begin
      for (int c = 0; c < NCH; c++) begin
        diff_r[c] <= diff_t'(mean_now_r[c]) - diff_t'(mean_last_r[c]);
      end
    end
  end

  // ---- gain multiply (33 x 11 signed, full 44-bit product) into the output register
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      prod[c]     = diff_r[c] * $signed({1'b0, gain_r});
      rate_nxt[c] = rate_t'(prod[c]);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int c = 0; c < NCH; c++) begin
        rate_r[c] <= rate_nxt[c];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pitch_rate  = rate_r[0];
  assign out_yaw_rate    = rate_r[1];
  assign out_feeder_rate = rate_r[2];

endmodule

`default_nettype wire

// ===== sv/tmas_checker.sv =====
// Port-level checker for the trimmed-mean angle speed block, bound to the top level.
// Depends on tmas_pkg and trimmed_mean_angle_speed_assert.svh.
`default_nettype none

module tmas_checker (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire tmas_pkg::rate_t  out_pitch_rate,
  input wire tmas_pkg::rate_t  out_yaw_rate,
  input wire tmas_pkg::rate_t  out_feeder_rate
);

  import tmas_pkg::*;

  `include "trimmed_mean_angle_speed_assert.svh"

  // a stalled result stays offered
  `TMAS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // a stalled result keeps its payload
  `TMAS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready,
    $stable(out_pitch_rate) && $stable(out_yaw_rate) && $stable(out_feeder_rate))

  // a fresh result into an empty output register is traced back to the item that ended its window
  `TMAS_ASSERT_SAME(a_out_latency, clk, rst_n, $rose(out_valid),
    $past(in_valid && in_ready, 4))

endmodule

bind trimmed_mean_angle_speed tmas_checker u_tmas_checker (.*);

`default_nettype wire
